FILE: sv/mwm_pkg.sv
// Shared types, constants and register indexes of the mecanum wheel mixer.
package mwm_pkg;

	// Default joystick sample width
	localparam int MWM_SAMPLE_BITS = 16;

	// Configuration port
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int DB_THR_BITS   = 15;
	localparam int GAIN_BITS     = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_DEADBAND  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_SLOW_GAIN = CFG_IDX_BITS'(1);

	localparam logic [DB_THR_BITS-1:0] DB_THR_RESET    = DB_THR_BITS'(3277);
	localparam logic [GAIN_BITS-1:0]   SLOW_GAIN_RESET = GAIN_BITS'(29789);

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DB,
		ST_MIX,
		ST_PEAK,
		ST_LOAD,
		ST_STEP,
		ST_STORE,
		ST_FIN
	} state_t;

	// Which motion command is being conditioned
	typedef enum logic [1:0] {
		CMD_DRIVE,
		CMD_SLIDE,
		CMD_SPIN
	} cmd_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       load_in;
		logic       mul;
		logic       db;
		logic       mix;
		logic       peak;
		logic       div_load;
		logic       div_step;
		logic       div_store;
		logic       fin;
		logic       first;
		cmd_sel_t   cmd_sel;
		logic [1:0] wheel_sel;
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic norm;
		logic out_free;
	} sts_t;

endpackage

FILE: sv/mwm_ctrl.sv
// Sequencer of the mecanum wheel mixer: conditioning, mixing and serial division steps.
module mwm_ctrl #(
	parameter int SAMPLE_BITS = mwm_pkg::MWM_SAMPLE_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mwm_pkg::sts_t sts,
	output mwm_pkg::ctl_t ctl
);
	import mwm_pkg::*;

	localparam int SW = $clog2(SAMPLE_BITS + 1);

	state_t   state_q, state_d;
	cmd_sel_t cmd_q;
	logic [1:0]    wheel_q;
	logic [SW-1:0] step_q;
	logic          last_step;

	assign last_step = (step_q == SW'(SAMPLE_BITS));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_MUL;
			ST_MUL:   state_d = ST_DB;
			ST_DB:    state_d = (cmd_q == CMD_SPIN) ? ST_MIX : ST_MUL;
			ST_MIX:   state_d = ST_PEAK;
			ST_PEAK:  state_d = ST_LOAD;
			ST_LOAD:  state_d = sts.norm ? ST_STEP : ST_FIN;
			ST_STEP:  if (last_step) state_d = ST_STORE;
			ST_STORE: state_d = (wheel_q == 2'd3) ? ST_FIN : ST_LOAD;
			ST_FIN:   if (sts.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		ctl           = '0;
		ctl.cmd_sel   = cmd_q;
		ctl.wheel_sel = wheel_q;
		ctl.first     = (step_q == '0);
		in_ready      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				ctl.load_in = in_valid;
			end
			ST_MUL:   ctl.mul       = 1'b1;
			ST_DB:    ctl.db        = 1'b1;
			ST_MIX:   ctl.mix       = 1'b1;
			ST_PEAK:  ctl.peak      = 1'b1;
			ST_LOAD:  ctl.div_load  = sts.norm;
			ST_STEP:  ctl.div_step  = 1'b1;
			ST_STORE: ctl.div_store = 1'b1;
			ST_FIN:   ctl.fin       = sts.out_free;
			default: ;
		endcase
	end

	// State and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_DRIVE;
			wheel_q <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: cmd_q <= CMD_DRIVE;
				ST_DB: begin
					case (cmd_q)
						CMD_DRIVE: cmd_q <= CMD_SLIDE;
						CMD_SLIDE: cmd_q <= CMD_SPIN;
						default:   cmd_q <= CMD_DRIVE;
					endcase
				end
				ST_PEAK:  wheel_q <= '0;
				ST_LOAD:  step_q  <= '0;
				ST_STEP:  step_q  <= step_q + SW'(1);
				ST_STORE: wheel_q <= wheel_q + 2'd1;
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STEP |-> step_q <= SW'(SAMPLE_BITS))
		else $error("divider step count overran");
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_MUL && cmd_q == CMD_DRIVE))
		else $error("item accepted but conditioning did not start with drive");
	a_div_norm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STEP |-> sts.norm)
		else $error("divider running without normalization");
`endif

endmodule

FILE: sv/mwm_dpath.sv
// Datapath of the mecanum wheel mixer: conditioning, mixing, peak search, divider, output register.
module mwm_dpath #(
	parameter int SAMPLE_BITS = mwm_pkg::MWM_SAMPLE_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mwm_pkg::ctl_t                         ctl,
	output mwm_pkg::sts_t                         sts,
	input  logic signed [SAMPLE_BITS-1:0]         stick_forward,
	input  logic signed [SAMPLE_BITS-1:0]         stick_strafe,
	input  logic signed [SAMPLE_BITS-1:0]         throttle_axis,
	input  logic signed [SAMPLE_BITS-1:0]         twist_axis,
	input  logic                                  slow_on_button,
	input  logic                                  slow_off_button,
	input  logic                                  wr_en,
	input  logic [mwm_pkg::CFG_IDX_BITS-1:0]      wr_index,
	input  logic [mwm_pkg::CFG_DATA_BITS-1:0]     wr_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [SAMPLE_BITS-1:0]         front_left_cmd,
	output logic signed [SAMPLE_BITS-1:0]         front_right_cmd,
	output logic signed [SAMPLE_BITS-1:0]         back_left_cmd,
	output logic signed [SAMPLE_BITS-1:0]         back_right_cmd
);
	import mwm_pkg::*;

	localparam int W  = SAMPLE_BITS;
	localparam int CW = W + 1;            // conditioned command
	localparam int WW = W + 3;            // mixed wheel speed
	localparam int MW = W + 1;            // wheel magnitude
	localparam int RW = MW + 1;           // divider remainder
	localparam int QW = W + 1;            // divider quotient
	localparam int PW = CW + GAIN_BITS;   // slow-mode product
	localparam int TW = (CW > DB_THR_BITS) ? CW : DB_THR_BITS;

	localparam logic [MW-1:0] UNIT = MW'(1) << (W - 1);
	localparam logic signed [WW-1:0] SAT_HI = WW'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [WW-1:0] SAT_LO = WW'(-(64'sd1 <<< (W - 1)));
	localparam logic [PW-1:0] HALF_LSB = PW'(1) << (GAIN_BITS - 1);

	// Configuration and mode
	logic [DB_THR_BITS-1:0] db_thr_q;
	logic [GAIN_BITS-1:0]   gain_q;
	logic                   slow_mode_q;

	// Captured item
	logic signed [W-1:0] fwd_q, str_q, thr_q, twi_q;

	// Conditioning
	logic signed [CW-1:0] raw_cmd;
	logic                 raw_neg;
	logic [CW-1:0]        raw_mag;
	logic [PW-1:0]        prod_q;
	logic [CW-1:0]        mag_q;
	logic                 neg_q;
	logic [PW-1:0]        prod_rnd;
	logic [CW-1:0]        sel_mag;
	logic signed [CW-1:0] cond_val;
	logic signed [CW-1:0] drive_q, slide_q, spin_q;

	// Mixing, peak and division
	logic signed [WW-1:0] wheel_q [4];
	logic [MW-1:0]        wmag [4];
	logic [MW-1:0]        max01, max23, peak_d;
	logic [MW-1:0]        peak_q;
	logic                 norm_q;
	logic [RW-1:0]        rem_q, trial;
	logic                 ge;
	logic [QW-1:0]        quo_q;
	logic [QW-1:0]        quo_rnd;
	logic signed [CW-1:0] res_q [4];

	// Output register
	logic                 out_valid_q;
	logic signed [W-1:0]  out_q [4];
	logic signed [WW-1:0] sat_val [4];

	assign sts.norm     = norm_q;
	assign sts.out_free = !out_valid_q || out_ready;

	// Configuration writes, unknown index dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_thr_q <= DB_THR_RESET;
			gain_q   <= SLOW_GAIN_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_DEADBAND:  db_thr_q <= wr_data[DB_THR_BITS-1:0];
				REG_SLOW_GAIN: gain_q   <= wr_data[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Slow mode: off button wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_mode_q <= 1'b0;
		end else if (ctl.load_in) begin
			if (slow_off_button)
				slow_mode_q <= 1'b0;
			else if (slow_on_button)
				slow_mode_q <= 1'b1;
		end
	end

	// Capture the axes
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			fwd_q <= stick_forward;
			str_q <= stick_strafe;
			thr_q <= throttle_axis;
			twi_q <= twist_axis;
		end
	end

	// Form the raw command: drive, negated strafe, twist minus throttle
	always_comb begin
		case (ctl.cmd_sel)
			CMD_DRIVE: raw_cmd = CW'(fwd_q);
			CMD_SLIDE: raw_cmd = -CW'(str_q);
			CMD_SPIN:  raw_cmd = CW'(twi_q) - CW'(thr_q);
			default:   raw_cmd = '0;
		endcase
		raw_neg = raw_cmd[CW-1];
		raw_mag = raw_neg ? CW'(-raw_cmd) : CW'(raw_cmd);
	end

	// Scale the magnitude by the slow gain
	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_q <= PW'(raw_mag) * PW'(gain_q);
			mag_q  <= raw_mag;
			neg_q  <= raw_neg;
		end
	end

	// Round, apply deadband, restore sign
	always_comb begin
		prod_rnd = prod_q + HALF_LSB;
		sel_mag  = slow_mode_q ? prod_rnd[PW-1:GAIN_BITS] : mag_q;
		if (TW'(sel_mag) < TW'(db_thr_q))
			cond_val = '0;
		else
			cond_val = neg_q ? -$signed(sel_mag) : $signed(sel_mag);
	end

	always_ff @(posedge clk) begin
		if (ctl.db) begin
			case (ctl.cmd_sel)
				CMD_DRIVE: drive_q <= cond_val;
				CMD_SLIDE: slide_q <= cond_val;
				CMD_SPIN:  spin_q  <= cond_val;
				default: ;
			endcase
		end
	end

	// Mix into the four wheels
	always_ff @(posedge clk) begin
		if (ctl.mix) begin
			wheel_q[0] <=  WW'(slide_q) + WW'(drive_q) + WW'(spin_q);
			wheel_q[1] <= -WW'(slide_q) + WW'(drive_q) - WW'(spin_q);
			wheel_q[2] <= -WW'(slide_q) + WW'(drive_q) + WW'(spin_q);
			wheel_q[3] <=  WW'(slide_q) + WW'(drive_q) - WW'(spin_q);
		end
	end

	// Wheel magnitudes and their maximum
	always_comb begin
		for (int i = 0; i < 4; i++)
			wmag[i] = wheel_q[i][WW-1] ? MW'(-wheel_q[i]) : MW'(wheel_q[i]);
		max01  = (wmag[0] > wmag[1]) ? wmag[0] : wmag[1];
		max23  = (wmag[2] > wmag[3]) ? wmag[2] : wmag[3];
		peak_d = (max01 > max23) ? max01 : max23;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_q <= 1'b0;
		end else if (ctl.peak) begin
			norm_q <= (peak_d > UNIT);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.peak)
			peak_q <= peak_d;
	end

	// Restoring divider: magnitude * 2^W / peak, one quotient bit per step
	always_comb begin
		trial = ctl.first ? rem_q : (rem_q << 1);
		ge    = (trial >= RW'(peak_q));
	end

	always_ff @(posedge clk) begin
		if (ctl.div_load) begin
			rem_q <= RW'(wmag[ctl.wheel_sel]);
			quo_q <= '0;
		end else if (ctl.div_step) begin
			rem_q <= ge ? (trial - RW'(peak_q)) : trial;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	// Round half away from zero and reapply the wheel sign
	assign quo_rnd = (quo_q + QW'(1)) >> 1;

	always_ff @(posedge clk) begin
		if (ctl.div_store) begin
			if (wheel_q[ctl.wheel_sel][WW-1])
				res_q[ctl.wheel_sel] <= -$signed(CW'(quo_rnd));
			else
				res_q[ctl.wheel_sel] <= $signed(CW'(quo_rnd));
		end
	end

	// Pick normalized or raw wheel, negate left wheels, saturate
	always_comb begin
		logic signed [WW-1:0] v;
		for (int i = 0; i < 4; i++) begin
			v = norm_q ? WW'(res_q[i]) : wheel_q[i];
			if (i == 0 || i == 2)
				v = -v;
			if (v > SAT_HI)
				sat_val[i] = SAT_HI;
			else if (v < SAT_LO)
				sat_val[i] = SAT_LO;
			else
				sat_val[i] = v;
		end
	end

	// Hold the finished item until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			for (int i = 0; i < 4; i++)
				out_q[i] <= sat_val[i][W-1:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign front_left_cmd  = out_q[0];
	assign front_right_cmd = out_q[1];
	assign back_left_cmd   = out_q[2];
	assign back_right_cmd  = out_q[3];

`ifndef SYNTHESIS
	a_rem_below_peak: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ctl.div_step) |-> rem_q < RW'(peak_q))
		else $error("divider remainder not below divisor");
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_store |-> quo_q <= (QW'(1) << W))
		else $error("normalized quotient above unit");
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while held");
`endif

endmodule

FILE: sv/mecanum_wheel_mixer_core.sv
// Top level of the mecanum wheel mixer: stream ports, controller and datapath.
//
// Takes one joystick sample per item and returns one item of four wheel
// commands. Conditioning (slow-mode gain, deadband) of the three motion
// commands runs in turn on one shared multiplier, followed by mixing and peak
// search. When the largest wheel magnitude exceeds 1.0 a restoring divider,
// shared by the four wheels, normalizes each wheel in turn (load, quotient
// steps, store) before the result is ready. The next item is accepted in the
// cycle after the result has entered the output register, which holds it
// while the downstream side stalls. Registers are to be written by the user
// only while the block is idle; the block itself does not enforce this. They
// take effect on the next item.
module mecanum_wheel_mixer_core #(
	parameter int SAMPLE_BITS = mwm_pkg::MWM_SAMPLE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// stick_forward, stick_strafe, throttle_axis, twist_axis,
	// slow_on_button, slow_off_button, zero pad
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((4*SAMPLE_BITS+2+7)/8)*8-1:0] s_tdata,
	// front_left_cmd, front_right_cmd, back_left_cmd, back_right_cmd, zero pad
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [((4*SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,
	input  logic                              wr_en,
	input  logic [mwm_pkg::CFG_IDX_BITS-1:0]  wr_index,
	input  logic [mwm_pkg::CFG_DATA_BITS-1:0] wr_data
);
	import mwm_pkg::*;

	localparam int W        = SAMPLE_BITS;
	localparam int OUT_BITS = 4 * W;
	localparam int OUT_WID  = ((4 * SAMPLE_BITS + 7) / 8) * 8;

	ctl_t ctl;
	sts_t sts;

	logic signed [W-1:0] fl_cmd, fr_cmd, bl_cmd, br_cmd;

	mwm_ctrl #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	mwm_dpath #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.stick_forward   (s_tdata[W-1:0]),
		.stick_strafe    (s_tdata[2*W-1:W]),
		.throttle_axis   (s_tdata[3*W-1:2*W]),
		.twist_axis      (s_tdata[4*W-1:3*W]),
		.slow_on_button  (s_tdata[4*W]),
		.slow_off_button (s_tdata[4*W+1]),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.front_left_cmd  (fl_cmd),
		.front_right_cmd (fr_cmd),
		.back_left_cmd   (bl_cmd),
		.back_right_cmd  (br_cmd)
	);

	// Pack the wheels, front left lowest
	assign m_tdata = OUT_WID'(OUT_BITS'({br_cmd, bl_cmd, fr_cmd, fl_cmd}));

endmodule
